// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FRBS_ASSERT_IMP(lbl, clk_i, rst_n_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FRBS_ASSERT_NXT(lbl, clk_i, rst_n_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/frbs_pkg.sv -----
// ---------------------------------------------------------------------------
// frbs_pkg
// types and constants of the fault recovery backoff sequencer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package frbs_pkg;

	localparam int DELAY_W   = 16;
	localparam int BACKOFF_W = 24;
	localparam int ATT_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DW    = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_BUS_RESTART   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_SETTLE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_INIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MAX   = 3'd4;

	localparam logic [DELAY_W-1:0]   BUS_RESTART_RST   = 16'd10;
	localparam logic [DELAY_W-1:0]   RESET_LOW_RST     = 16'd10;
	localparam logic [DELAY_W-1:0]   RESET_SETTLE_RST  = 16'd100;
	localparam logic [BACKOFF_W-1:0] BACKOFF_INIT_RST  = 24'd1000;
	localparam logic [BACKOFF_W-1:0] BACKOFF_MAX_RST   = 24'd60000;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_INIT  = 2'd1,
		REQ_CHECK = 2'd2,
		REQ_MARK  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		HLT_HEALTHY    = 2'd0,
		HLT_UNHEALTHY  = 2'd1,
		HLT_RECOVERING = 2'd2
	} health_t;

	typedef enum logic [2:0] {
		ACT_NONE        = 3'd0,
		ACT_START_RECOV = 3'd1,
		ACT_STOP_BUS    = 3'd2,
		ACT_START_BUS   = 3'd3,
		ACT_RESET_LOW   = 3'd4,
		ACT_RESET_HIGH  = 3'd5,
		ACT_REINIT      = 3'd6
	} act_t;

	typedef enum logic [2:0] {
		STEP_STOP_BUS   = 3'd0,
		STEP_START_BUS  = 3'd1,
		STEP_RESET_LOW  = 3'd2,
		STEP_RESET_HIGH = 3'd3,
		STEP_REINIT     = 3'd4
	} step_t;

	typedef struct packed {
		logic [DELAY_W-1:0]   bus_restart_delay_ms;
		logic [DELAY_W-1:0]   reset_low_ms;
		logic [DELAY_W-1:0]   reset_settle_ms;
		logic [BACKOFF_W-1:0] backoff_initial_ms;
		logic [BACKOFF_W-1:0] backoff_max_ms;
	} cfg_t;

	typedef struct packed {
		logic                 check_ok;
		logic [BACKOFF_W-1:0] backoff_now;
		logic [ATT_W-1:0]     attempt_count;
		act_t                 action;
		health_t              health_state;
	} res_t;

endpackage

// ----- rtl/frbs_cfg.sv -----
// ---------------------------------------------------------------------------
// frbs_cfg
// configuration register file, write only
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module frbs_cfg
	import frbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] addr,
	input  logic [CFG_DW-1:0]    wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bus_restart_delay_ms <= BUS_RESTART_RST;
			cfg_q.reset_low_ms         <= RESET_LOW_RST;
			cfg_q.reset_settle_ms      <= RESET_SETTLE_RST;
			cfg_q.backoff_initial_ms   <= BACKOFF_INIT_RST;
			cfg_q.backoff_max_ms       <= BACKOFF_MAX_RST;
		end else if (wr_en) begin
			case (addr)
				CFG_BUS_RESTART:  cfg_q.bus_restart_delay_ms <= wdata[DELAY_W-1:0];
				CFG_RESET_LOW:    cfg_q.reset_low_ms         <= wdata[DELAY_W-1:0];
				CFG_RESET_SETTLE: cfg_q.reset_settle_ms      <= wdata[DELAY_W-1:0];
				CFG_BACKOFF_INIT: cfg_q.backoff_initial_ms   <= wdata[BACKOFF_W-1:0];
				CFG_BACKOFF_MAX:  cfg_q.backoff_max_ms       <= wdata[BACKOFF_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/frbs_core.sv -----
// ---------------------------------------------------------------------------
// frbs_core
// health state, backoff timer and recovery step sequencing
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frbs_core
	import frbs_pkg::*;
#(
	parameter int TIME_WIDTH = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  req_t req,
	input  logic probe,
	input  cfg_t cfg,
	output res_t res
);

	localparam int CmpW = (TIME_WIDTH > BACKOFF_W) ? TIME_WIDTH : BACKOFF_W;
	localparam logic [TIME_WIDTH-1:0] SinceMax = {TIME_WIDTH{1'b1}};

	health_t                health_q, health_d;
	step_t                  step_q, step_d;
	logic [BACKOFF_W-1:0]   backoff_q, backoff_d;
	logic [TIME_WIDTH-1:0]  since_q, since_d;
	logic [DELAY_W-1:0]     wait_q, wait_d;
	logic [ATT_W-1:0]       attempts_q, attempts_d;
	act_t                   act;
	logic                   ok;

	logic [TIME_WIDTH-1:0]  since_inc;
	logic                   start_rec;
	logic [DELAY_W-1:0]     wait_dec;
	logic [BACKOFF_W:0]     backoff_dbl;
	logic [BACKOFF_W-1:0]   backoff_next;
	logic [ATT_W-1:0]       attempts_inc;

	assign since_inc    = (since_q != SinceMax) ? since_q + 1'b1 : since_q;
	assign start_rec    = (CmpW'(since_inc) >= CmpW'(backoff_q)) || (since_inc == SinceMax);
	assign wait_dec     = (wait_q != '0) ? wait_q - 1'b1 : wait_q;
	assign backoff_dbl  = {backoff_q, 1'b0};
	assign backoff_next = (backoff_dbl < {1'b0, cfg.backoff_max_ms}) ?
	                      backoff_dbl[BACKOFF_W-1:0] : cfg.backoff_max_ms;
	assign attempts_inc = (attempts_q != {ATT_W{1'b1}}) ? attempts_q + 1'b1 : attempts_q;

	always_comb begin
		health_d   = health_q;
		step_d     = step_q;
		backoff_d  = backoff_q;
		since_d    = since_q;
		wait_d     = wait_q;
		attempts_d = attempts_q;
		act        = ACT_NONE;
		ok         = 1'b0;
		case (req)
			REQ_TICK: begin
				case (health_q)
					HLT_UNHEALTHY: begin
						if (start_rec) begin
							attempts_d = attempts_inc;
							since_d    = '0;
							step_d     = STEP_STOP_BUS;
							wait_d     = '0;
							health_d   = HLT_RECOVERING;
							act        = ACT_START_RECOV;
						end else begin
							since_d = since_inc;
						end
					end
					HLT_RECOVERING: begin
						wait_d = wait_dec;
						if (wait_dec == '0) begin
							case (step_q)
								STEP_STOP_BUS: begin
									act    = ACT_STOP_BUS;
									wait_d = cfg.bus_restart_delay_ms;
									step_d = STEP_START_BUS;
								end
								STEP_START_BUS: begin
									act    = ACT_START_BUS;
									wait_d = cfg.bus_restart_delay_ms;
									step_d = STEP_RESET_LOW;
								end
								STEP_RESET_LOW: begin
									act    = ACT_RESET_LOW;
									wait_d = cfg.reset_low_ms;
									step_d = STEP_RESET_HIGH;
								end
								STEP_RESET_HIGH: begin
									act    = ACT_RESET_HIGH;
									wait_d = cfg.reset_settle_ms;
									step_d = STEP_REINIT;
								end
								STEP_REINIT: begin
									act    = ACT_REINIT;
									step_d = STEP_STOP_BUS;
									wait_d = '0;
									if (probe) begin
										health_d   = HLT_HEALTHY;
										backoff_d  = cfg.backoff_initial_ms;
										attempts_d = '0;
										since_d    = SinceMax;
									end else begin
										health_d  = HLT_UNHEALTHY;
										since_d   = '0;
										backoff_d = backoff_next;
									end
								end
								default: begin
									health_d = HLT_UNHEALTHY;
									step_d   = STEP_STOP_BUS;
								end
							endcase
						end
					end
					default: ;
				endcase
			end
			REQ_INIT: begin
				step_d  = STEP_STOP_BUS;
				wait_d  = '0;
				since_d = SinceMax;
				if (probe) begin
					health_d  = HLT_HEALTHY;
					backoff_d = cfg.backoff_initial_ms;
					ok        = 1'b1;
				end else begin
					health_d = HLT_UNHEALTHY;
				end
			end
			REQ_CHECK: begin
				if (health_q == HLT_HEALTHY) begin
					if (probe) begin
						ok = 1'b1;
					end else begin
						health_d   = HLT_UNHEALTHY;
						step_d     = STEP_STOP_BUS;
						wait_d     = '0;
						attempts_d = '0;
						since_d    = SinceMax;
					end
				end
			end
			REQ_MARK: begin
				if (health_q != HLT_RECOVERING) begin
					health_d   = HLT_UNHEALTHY;
					step_d     = STEP_STOP_BUS;
					wait_d     = '0;
					attempts_d = '0;
					since_d    = SinceMax;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			health_q   <= HLT_UNHEALTHY;
			step_q     <= STEP_STOP_BUS;
			backoff_q  <= BACKOFF_INIT_RST;
			since_q    <= SinceMax;
			wait_q     <= '0;
			attempts_q <= '0;
		end else if (fire) begin
			health_q   <= health_d;
			step_q     <= step_d;
			backoff_q  <= backoff_d;
			since_q    <= since_d;
			wait_q     <= wait_d;
			attempts_q <= attempts_d;
		end
	end

	assign res.health_state  = health_d;
	assign res.action        = act;
	assign res.attempt_count = attempts_d;
	assign res.backoff_now   = backoff_d;
	assign res.check_ok      = ok;

	`FRBS_ASSERT_IMP(a_unhealthy_idle_seq, clk, arst_n,
		health_q == HLT_UNHEALTHY, step_q == STEP_STOP_BUS && wait_q == '0,
		"unhealthy with a recovery step pending")
	`FRBS_ASSERT_IMP(a_step_bounded, clk, arst_n,
		1'b1, step_q <= STEP_REINIT, "recovery step out of range")
	`FRBS_ASSERT_NXT(a_wait_counts_down, clk, arst_n,
		fire && req == REQ_TICK && health_q == HLT_RECOVERING && wait_q > 16'd1,
		health_q == HLT_RECOVERING && wait_q == $past(wait_q) - 1'b1,
		"recovery wait did not count down")

endmodule

// ----- rtl/fault_recovery_backoff_sequencer_top.sv -----
// ---------------------------------------------------------------------------
// fault_recovery_backoff_sequencer_top
// health and exponential backoff recovery sequencer for a peripheral
// ---------------------------------------------------------------------------
// Takes one beat per clock on the slave side (tick, init result, health check
// or mark unhealthy in s_tuser, probe answer in s_tdata) and returns exactly
// one result beat for each. Throughput is one beat per cycle while the master
// side is ready: the whole state update is one pass of next-state logic
// between the input register and the result register, and a stalled result
// register holds the input register too. The user must write configuration
// registers only while no beat is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fault_recovery_backoff_sequencer_top
	import frbs_pkg::*;
#(
	parameter int TIME_WIDTH = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // [0] probe_ok
	input  logic [1:0]           s_tuser,  // [1:0] req_type
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [1:0] health_state, [4:2] action, [20:5] attempt_count,
	// [44:21] backoff_now, [45] check_ok
	output logic [47:0]          m_tdata,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_DW-1:0]    cfg_wdata
);

	cfg_t cfg;
	res_t res;

	logic valid_s1;
	req_t req_s1;
	logic probe_s1;
	logic valid_s2;
	res_t res_s2;
	logic advance;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1   <= req_t'(s_tuser);
			probe_s1 <= s_tdata[0];
		end
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	frbs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.addr   (cfg_addr),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	frbs_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance && valid_s1),
		.req    (req_s1),
		.probe  (probe_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.check_ok, res_s2.backoff_now, res_s2.attempt_count,
	                   res_s2.action, res_s2.health_state};

	`FRBS_ASSERT_NXT(a_s1_moves_to_s2, clk, arst_n,
		valid_s1 && advance, valid_s2, "input register beat lost")
	`FRBS_ASSERT_NXT(a_s1_held_on_stall, clk, arst_n,
		valid_s1 && !advance, valid_s1 && $stable(req_s1) && $stable(probe_s1),
		"input register changed while stalled")

endmodule
